// File: rtl/prac_pkg.sv
// Shared constants and arctangent table for the point rotation pipeline.
`timescale 1ns / 1ps
`default_nettype none

package prac_pkg;

	localparam int COORD_W      = 32;
	localparam int ANGLE_W      = 17;
	localparam int CORDIC_W     = 33;
	localparam int Z_W          = 32;
	localparam int ATAN_ENTRIES = 30;

	localparam int HALF_TURN    = 180 * 128;
	localparam int QUARTER_TURN = HALF_TURN / 2;
	localparam int FULL_TURN    = HALF_TURN * 2;

	localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 33'sd652032874;

	// atan(2^-i) in units of 2^-23 degree
	function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] idx);
		logic signed [Z_W-1:0] v;
		case (idx)
			5'd0:    v = 32'sd377487360;
			5'd1:    v = 32'sd222843801;
			5'd2:    v = 32'sd117744544;
			5'd3:    v = 32'sd59768969;
			5'd4:    v = 32'sd30000467;
			5'd5:    v = 32'sd15014858;
			5'd6:    v = 32'sd7509261;
			5'd7:    v = 32'sd3754860;
			5'd8:    v = 32'sd1877459;
			5'd9:    v = 32'sd938733;
			5'd10:   v = 32'sd469367;
			5'd11:   v = 32'sd234683;
			5'd12:   v = 32'sd117342;
			5'd13:   v = 32'sd58671;
			5'd14:   v = 32'sd29335;
			5'd15:   v = 32'sd14668;
			5'd16:   v = 32'sd7334;
			5'd17:   v = 32'sd3667;
			5'd18:   v = 32'sd1833;
			5'd19:   v = 32'sd917;
			5'd20:   v = 32'sd458;
			5'd21:   v = 32'sd229;
			5'd22:   v = 32'sd115;
			5'd23:   v = 32'sd57;
			5'd24:   v = 32'sd29;
			5'd25:   v = 32'sd14;
			5'd26:   v = 32'sd7;
			5'd27:   v = 32'sd4;
			5'd28:   v = 32'sd2;
			5'd29:   v = 32'sd1;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: rtl/point_rotation_about_center.sv
// Pipelined rotation of a Q16.16 point about a center, CORDIC sine/cosine.
// Registers from accepted start to the done strobe: stage 1, stage 2, the CORDIC
// stages (one register stage per CORDIC iteration), stages 3 to 5, then the output.
// Throughput: one item per cycle while busy is low; the result side cannot stall.
// busy is set by reset and is cleared by the first clock after reset; it then stays low.
// Reset clears all valid bits; in-flight items are dropped.
`timescale 1ns / 1ps
`default_nettype none

module point_rotation_about_center #(
	parameter int CORDIC_STEPS = 20
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic signed [prac_pkg::COORD_W-1:0]   point_x,
	input  wire logic signed [prac_pkg::COORD_W-1:0]   point_y,
	input  wire logic signed [prac_pkg::COORD_W-1:0]   center_x,
	input  wire logic signed [prac_pkg::COORD_W-1:0]   center_y,
	input  wire logic signed [prac_pkg::ANGLE_W-1:0]   angle_deg,
	output logic                                        done,
	output logic signed [prac_pkg::COORD_W-1:0]        rotated_x,
	output logic signed [prac_pkg::COORD_W-1:0]        rotated_y,
	output logic                                        saturated
);

	localparam int NSTEPS = (CORDIC_STEPS > prac_pkg::ATAN_ENTRIES) ?
		prac_pkg::ATAN_ENTRIES : CORDIC_STEPS;
	localparam int CW = prac_pkg::CORDIC_W;
	localparam int ZW = prac_pkg::Z_W;
	localparam int PW = 2 * CW;
	localparam int RW = PW + 1 - 30;
	localparam int FW = RW + 1;

	localparam logic signed [17:0] FT18 = 18'(prac_pkg::FULL_TURN);
	localparam logic signed [17:0] HT18 = 18'(prac_pkg::HALF_TURN);
	localparam logic signed [17:0] QT18 = 18'(prac_pkg::QUARTER_TURN);
	localparam logic signed [ZW-1:0] Z_LIM = 32'(prac_pkg::QUARTER_TURN * 65536);
	localparam logic signed [ZW-1:0] Z_RES =
		32'(2 * prac_pkg::atan_lut(5'(NSTEPS - 1)) + 32);
	localparam logic signed [PW:0] RND_HALF = (PW + 1)'(64'sd1 <<< 29);
	localparam logic signed [prac_pkg::COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [prac_pkg::COORD_W-1:0] C_MIN = 32'sh8000_0000;

	// ---------------- stage 1: angle reduction, deltas
	logic                     busy_q;
	logic                     v_s1;
	logic [16:0]              red_s1;
	logic signed [CW-1:0]     dx_s1, dy_s1;
	logic signed [31:0]       cx_s1, cy_s1;
	logic signed [17:0]       ang_w, red_w;

	always_comb begin
		ang_w = {angle_deg[16], angle_deg};
		if (ang_w < -FT18) begin
			red_w = ang_w + 18'(2 * prac_pkg::FULL_TURN);
		end else if (ang_w < 18'sd0) begin
			red_w = ang_w + FT18;
		end else if (ang_w >= FT18) begin
			red_w = ang_w - FT18;
		end else begin
			red_w = ang_w;
		end
	end

	always_ff @(posedge clk) begin
		red_s1 <= red_w[16:0];
		dx_s1  <= {point_x[31], point_x} - {center_x[31], center_x};
		dy_s1  <= {point_y[31], point_y} - {center_y[31], center_y};
		cx_s1  <= center_x;
		cy_s1  <= center_y;
	end

	// ---------------- stage 2: fold to +-90 degrees
	logic                     v_s2;
	logic signed [ZW-1:0]     z_s2;
	logic                     neg_s2;
	logic signed [CW-1:0]     dx_s2, dy_s2;
	logic signed [31:0]       cx_s2, cy_s2;
	logic signed [17:0]       r_w, f_w;
	logic                     neg_w;

	always_comb begin
		r_w   = {1'b0, red_s1};
		neg_w = 1'b0;
		if (r_w > QT18 && r_w <= 18'(3 * prac_pkg::QUARTER_TURN)) begin
			f_w   = r_w - HT18;
			neg_w = 1'b1;
		end else if (r_w > 18'(3 * prac_pkg::QUARTER_TURN)) begin
			f_w = r_w - FT18;
		end else begin
			f_w = r_w;
		end
	end

	always_ff @(posedge clk) begin
		z_s2   <= {f_w[15:0], 16'h0000};
		neg_s2 <= neg_w;
		dx_s2  <= dx_s1;
		dy_s2  <= dy_s1;
		cx_s2  <= cx_s1;
		cy_s2  <= cy_s1;
	end

	// ---------------- CORDIC stages, one iteration each
	logic                     v_sc   [1:NSTEPS];
	logic signed [CW-1:0]     x_sc   [1:NSTEPS];
	logic signed [CW-1:0]     y_sc   [1:NSTEPS];
	logic signed [ZW-1:0]     z_sc   [1:NSTEPS];
	logic                     neg_sc [1:NSTEPS];
	logic signed [CW-1:0]     dx_sc  [1:NSTEPS];
	logic signed [CW-1:0]     dy_sc  [1:NSTEPS];
	logic signed [31:0]       cx_sc  [1:NSTEPS];
	logic signed [31:0]       cy_sc  [1:NSTEPS];

	for (genvar i = 0; i < NSTEPS; i++) begin : g_cordic
		logic                 vi, negi;
		logic signed [CW-1:0] xi, yi, dxi, dyi, xs, ys;
		logic signed [ZW-1:0] zi;
		logic signed [31:0]   cxi, cyi;

		if (i == 0) begin : g_first
			assign vi   = v_s2;
			assign xi   = prac_pkg::GAIN_Q30;
			assign yi   = '0;
			assign zi   = z_s2;
			assign negi = neg_s2;
			assign dxi  = dx_s2;
			assign dyi  = dy_s2;
			assign cxi  = cx_s2;
			assign cyi  = cy_s2;
		end else begin : g_next
			assign vi   = v_sc[i];
			assign xi   = x_sc[i];
			assign yi   = y_sc[i];
			assign zi   = z_sc[i];
			assign negi = neg_sc[i];
			assign dxi  = dx_sc[i];
			assign dyi  = dy_sc[i];
			assign cxi  = cx_sc[i];
			assign cyi  = cy_sc[i];
		end

		assign xs = xi >>> i;
		assign ys = yi >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sc[i+1] <= 1'b0;
			end else begin
				v_sc[i+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (!zi[ZW-1]) begin
				x_sc[i+1] <= xi - ys;
				y_sc[i+1] <= yi + xs;
				z_sc[i+1] <= zi - prac_pkg::atan_lut(5'(i));
			end else begin
				x_sc[i+1] <= xi + ys;
				y_sc[i+1] <= yi - xs;
				z_sc[i+1] <= zi + prac_pkg::atan_lut(5'(i));
			end
			neg_sc[i+1] <= negi;
			dx_sc[i+1]  <= dxi;
			dy_sc[i+1]  <= dyi;
			cx_sc[i+1]  <= cxi;
			cy_sc[i+1]  <= cyi;
		end
	end

	// ---------------- stage 3: quadrant sign
	logic                     v_s3;
	logic signed [CW-1:0]     cos_s3, sin_s3, dx_s3, dy_s3;
	logic signed [31:0]       cx_s3, cy_s3;

	always_ff @(posedge clk) begin
		cos_s3 <= neg_sc[NSTEPS] ? -x_sc[NSTEPS] : x_sc[NSTEPS];
		sin_s3 <= neg_sc[NSTEPS] ? -y_sc[NSTEPS] : y_sc[NSTEPS];
		dx_s3  <= dx_sc[NSTEPS];
		dy_s3  <= dy_sc[NSTEPS];
		cx_s3  <= cx_sc[NSTEPS];
		cy_s3  <= cy_sc[NSTEPS];
	end

	// ---------------- stage 4: products
	logic                     v_s4;
	logic signed [PW-1:0]     p_xc_s4, p_ys_s4, p_yc_s4, p_xs_s4;
	logic signed [31:0]       cx_s4, cy_s4;

	always_ff @(posedge clk) begin
		p_xc_s4 <= dx_s3 * cos_s3;
		p_ys_s4 <= dy_s3 * sin_s3;
		p_yc_s4 <= dy_s3 * cos_s3;
		p_xs_s4 <= dx_s3 * sin_s3;
		cx_s4   <= cx_s3;
		cy_s4   <= cy_s3;
	end

	// ---------------- stage 5: sum and round half up to Q16
	logic                     v_s5;
	logic signed [RW-1:0]     rnd_x_s5, rnd_y_s5;
	logic signed [31:0]       cx_s5, cy_s5;
	logic signed [PW:0]       sum_x_w, sum_y_w;

	always_comb begin
		sum_x_w = {p_xc_s4[PW-1], p_xc_s4} + {p_ys_s4[PW-1], p_ys_s4} + RND_HALF;
		sum_y_w = {p_yc_s4[PW-1], p_yc_s4} - {p_xs_s4[PW-1], p_xs_s4} + RND_HALF;
	end

	always_ff @(posedge clk) begin
		rnd_x_s5 <= sum_x_w[PW:30];
		rnd_y_s5 <= sum_y_w[PW:30];
		cx_s5    <= cx_s4;
		cy_s5    <= cy_s4;
	end

	// ---------------- output: add center, saturate
	logic                     done_q, sat_q;
	logic signed [31:0]       rx_q, ry_q;
	logic signed [FW-1:0]     fx_w, fy_w;
	logic [32:0]              clip_x_w, clip_y_w;

	function automatic logic [32:0] clip(input logic signed [FW-1:0] v);
		logic [32:0] r;
		if (!v[FW-1] && (|v[FW-2:31])) begin
			r = {1'b1, C_MAX};
		end else if (v[FW-1] && !(&v[FW-2:31])) begin
			r = {1'b1, C_MIN};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	always_comb begin
		fx_w     = {rnd_x_s5[RW-1], rnd_x_s5} + FW'(cx_s5);
		fy_w     = {rnd_y_s5[RW-1], rnd_y_s5} + FW'(cy_s5);
		clip_x_w = clip(fx_w);
		clip_y_w = clip(fy_w);
	end

	always_ff @(posedge clk) begin
		rx_q  <= clip_x_w[31:0];
		ry_q  <= clip_y_w[31:0];
		sat_q <= clip_x_w[32] | clip_y_w[32];
	end

	// ---------------- valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			v_s1   <= start & ~busy_q;
			v_s2   <= v_s1;
			v_s3   <= v_sc[NSTEPS];
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			done_q <= v_s5;
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign rotated_x = rx_q;
	assign rotated_y = ry_q;
	assign saturated = sat_q;

	// ---------------- assertions
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##(NSTEPS + 5) done)
		else $error("item did not reach done after pipeline latency");

	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (z_s2 <= Z_LIM && z_s2 >= -Z_LIM))
		else $error("folded angle outside +-90 degrees");

	a_residual: assert property (@(posedge clk) disable iff (!arst_n)
		v_sc[NSTEPS] |-> (z_sc[NSTEPS] <= Z_RES && z_sc[NSTEPS] >= -Z_RES))
		else $error("CORDIC residual angle did not converge");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (rotated_x == C_MAX || rotated_x == C_MIN ||
			rotated_y == C_MAX || rotated_y == C_MIN))
		else $error("saturated flag without a clipped coordinate");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v_s5))
		else $error("done without an item in the last stage");

endmodule

`default_nettype wire

// File: sim/rotation_checker.sv
// Checker for point_rotation_about_center: predicts each rotated point and compares.
`timescale 1ns / 1ps

module rotation_checker #(
	parameter int CORDIC_STEPS = 20
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic                                     busy,
	input  logic signed [prac_pkg::COORD_W-1:0]      point_x,
	input  logic signed [prac_pkg::COORD_W-1:0]      point_y,
	input  logic signed [prac_pkg::COORD_W-1:0]      center_x,
	input  logic signed [prac_pkg::COORD_W-1:0]      center_y,
	input  logic signed [prac_pkg::ANGLE_W-1:0]      angle_deg,
	input  logic                                     done,
	input  logic signed [prac_pkg::COORD_W-1:0]      rotated_x,
	input  logic signed [prac_pkg::COORD_W-1:0]      rotated_y,
	input  logic                                     saturated,
	output int                                       fail_count,
	output int                                       pending,
	output int                                       checked_count,
	output int                                       clipped_count
);

	typedef logic signed [67:0] wide_t;
	typedef logic signed [prac_pkg::COORD_W-1:0] coord_t;

	typedef struct {
		coord_t rx;
		coord_t ry;
		logic   sat;
	} rotated_point_t;

	localparam int ITERS = (CORDIC_STEPS > prac_pkg::ATAN_ENTRIES) ?
		prac_pkg::ATAN_ENTRIES : CORDIC_STEPS;
	localparam wide_t COORD_MAX = wide_t'(32'sh7FFFFFFF);
	localparam wide_t COORD_MIN = wide_t'(32'sh80000000);

	// atan(2^-i) in 2^-23 degree
	localparam longint ATAN_STEP [30] = '{
		377487360, 222843801, 117744544, 59768969, 30000467,
		15014858, 7509261, 3754860, 1877459, 938733,
		469367, 234683, 117342, 58671, 29335,
		14668, 7334, 3667, 1833, 917,
		458, 229, 115, 57, 29,
		14, 7, 4, 2, 1
	};

	rotated_point_t expected_points[$];

	function automatic coord_t round_and_clip(input wide_t acc, input coord_t base,
			inout logic sat);
		wide_t r;
		r = ((acc + wide_t'(64'sd536870912)) >>> 30) + wide_t'(base);
		if (r > COORD_MAX) begin
			r = COORD_MAX;
			sat = 1'b1;
		end else if (r < COORD_MIN) begin
			r = COORD_MIN;
			sat = 1'b1;
		end
		return coord_t'(r);
	endfunction

	function automatic rotated_point_t rotate_about_center(input coord_t px, input coord_t py,
			input coord_t cx, input coord_t cy,
			input logic signed [prac_pkg::ANGLE_W-1:0] ang);
		rotated_point_t res;
		int a;
		logic flip;
		longint cs, sn, z, xs, ys, dx, dy;
		wide_t acc;
		a = int'(ang) % prac_pkg::FULL_TURN;
		if (a < 0)
			a += prac_pkg::FULL_TURN;
		flip = 1'b0;
		if (a > prac_pkg::QUARTER_TURN && a <= 3 * prac_pkg::QUARTER_TURN) begin
			a -= prac_pkg::HALF_TURN;
			flip = 1'b1;
		end else if (a > 3 * prac_pkg::QUARTER_TURN) begin
			a -= prac_pkg::FULL_TURN;
		end
		z  = longint'(a) * 65536;
		cs = longint'(prac_pkg::GAIN_Q30);
		sn = 0;
		for (int i = 0; i < ITERS; i++) begin
			xs = cs >>> i;
			ys = sn >>> i;
			if (z >= 0) begin
				cs = cs - ys;
				sn = sn + xs;
				z  = z - ATAN_STEP[i];
			end else begin
				cs = cs + ys;
				sn = sn - xs;
				z  = z + ATAN_STEP[i];
			end
		end
		if (flip) begin
			cs = -cs;
			sn = -sn;
		end
		dx = longint'(px) - longint'(cx);
		dy = longint'(py) - longint'(cy);
		res.sat = 1'b0;
		acc = wide_t'(dx) * wide_t'(cs) + wide_t'(dy) * wide_t'(sn);
		res.rx = round_and_clip(acc, cx, res.sat);
		acc = wide_t'(dy) * wide_t'(cs) - wide_t'(dx) * wide_t'(sn);
		res.ry = round_and_clip(acc, cy, res.sat);
		return res;
	endfunction

	initial begin
		fail_count    = 0;
		pending       = 0;
		checked_count = 0;
		clipped_count = 0;
	end

	always @(posedge clk) begin
		rotated_point_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_points.size() == 0) begin
					$error("result with no item pending: x=%0d y=%0d sat=%0b",
						rotated_x, rotated_y, saturated);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_points.pop_front();
					if (rotated_x !== want.rx || rotated_y !== want.ry
							|| saturated !== want.sat)
						fail_count <= fail_count + 1;
					if (rotated_x !== want.rx)
						$error("rotated_x: expected %0d, got %0d", want.rx, rotated_x);
					if (rotated_y !== want.ry)
						$error("rotated_y: expected %0d, got %0d", want.ry, rotated_y);
					if (saturated !== want.sat)
						$error("saturated: expected %0b, got %0b", want.sat, saturated);
					checked_count <= checked_count + 1;
					if (want.sat)
						clipped_count <= clipped_count + 1;
				end
			end
			if (start && !busy)
				expected_points.insert(expected_points.size(),
					rotate_about_center(point_x, point_y, center_x, center_y, angle_deg));
			pending <= expected_points.size();
		end
	end

endmodule

// File: sim/tb_top.sv
// Testbench top for point_rotation_about_center: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

	localparam int STEPS        = 20;
	localparam int RAND_ITEMS   = 1200;
	localparam int CALM_TAIL    = 200;
	localparam int LIMIT_CYCLES = 400000;

	typedef logic signed [prac_pkg::COORD_W-1:0] coord_t;
	typedef logic signed [prac_pkg::ANGLE_W-1:0] angle_t;

	localparam coord_t MAXC = 32'sh7FFFFFFF;
	localparam coord_t MINC = 32'sh80000000;
	localparam coord_t ONE  = 32'sh00010000;
	localparam int DEG      = 128;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	coord_t point_x, point_y, center_x, center_y;
	angle_t angle_deg;
	logic   done;
	coord_t rotated_x, rotated_y;
	logic   saturated;

	int fail_count, pending, checked_count, clipped_count;
	int items_sent;
	int cycles;

	point_rotation_about_center #(.CORDIC_STEPS(STEPS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.point_x   (point_x),
		.point_y   (point_y),
		.center_x  (center_x),
		.center_y  (center_y),
		.angle_deg (angle_deg),
		.done      (done),
		.rotated_x (rotated_x),
		.rotated_y (rotated_y),
		.saturated (saturated)
	);

	rotation_checker #(.CORDIC_STEPS(STEPS)) chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.point_x       (point_x),
		.point_y       (point_y),
		.center_x      (center_x),
		.center_y      (center_y),
		.angle_deg     (angle_deg),
		.done          (done),
		.rotated_x     (rotated_x),
		.rotated_y     (rotated_y),
		.saturated     (saturated),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked_count (checked_count),
		.clipped_count (clipped_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("timeout after %0d cycles", cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic send_point(input coord_t px, input coord_t py, input coord_t cx,
			input coord_t cy, input int ang);
		@(negedge clk);
		point_x   = px;
		point_y   = py;
		center_x  = cx;
		center_y  = cy;
		angle_deg = angle_t'(ang);
		start     = 1'b1;
		do
			@(posedge clk);
		while (busy);
		items_sent++;
	endtask

	task automatic idle_burst(input int n);
		@(negedge clk);
		start = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 5))
			0, 1:    return coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
			2:       return coord_t'($urandom);
			3:       return MAXC - coord_t'($urandom_range(0, 65535));
			4:       return MINC + coord_t'($urandom_range(0, 65535));
			default: return coord_t'((int'($urandom_range(0, 2000)) - 1000) * 65536);
		endcase
	endfunction

	function automatic int rand_angle();
		case ($urandom_range(0, 7))
			0:       return int'($urandom_range(0, 131071));
			1:       return (int'($urandom_range(0, 8)) - 4) * prac_pkg::QUARTER_TURN
					+ int'($urandom_range(0, 2)) - 1;
			default: return int'($urandom_range(0, 2 * prac_pkg::FULL_TURN))
					- prac_pkg::FULL_TURN;
		endcase
	endfunction

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		point_x    = '0;
		point_y    = '0;
		center_x   = '0;
		center_y   = '0;
		angle_deg  = '0;
		items_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// quadrant turns and their fold boundaries
		send_point('0, '0, '0, '0, 0);
		send_point(ONE, '0, '0, '0, 90 * DEG);
		send_point(ONE, 2 * ONE, '0, '0, 180 * DEG);
		send_point(ONE, '0, ONE, ONE, 270 * DEG);
		send_point(3 * ONE, ONE, ONE, '0, 360 * DEG);
		send_point(ONE, ONE, '0, '0, -90 * DEG);
		send_point(ONE, -ONE, '0, '0, -360 * DEG);
		send_point(5 * ONE, 7 * ONE, ONE, '0, prac_pkg::QUARTER_TURN + 1);
		send_point(5 * ONE, 7 * ONE, ONE, '0, 3 * prac_pkg::QUARTER_TURN + 1);
		send_point(5 * ONE, 7 * ONE, ONE, '0, 45 * DEG);
		// angles past a full turn wrap
		send_point(ONE, ONE, '0, '0, 65535);
		send_point(ONE, ONE, '0, '0, -65536);
		// coordinate extremes and clipping in both directions
		send_point(MAXC, MAXC, MINC, MINC, 0);
		send_point(MINC, MINC, MAXC, MAXC, 180 * DEG);
		send_point(MAXC, MAXC, MINC, MINC, 180 * DEG);
		send_point(MAXC, MINC, MINC, MAXC, 90 * DEG);
		send_point(MINC, MAXC, MAXC, MINC, -90 * DEG);
		send_point(MAXC, MAXC, MAXC, MAXC, 45 * DEG);
		send_point(MINC, MINC, MINC, MINC, 135 * DEG);
		send_point(MAXC, '0, '0, '0, 45 * DEG);
		send_point(MINC, MINC, '0, '0, -45 * DEG);
		send_point(-1, 1, '0, '0, 1);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i < RAND_ITEMS - CALM_TAIL && (i / 100) % 3 != 2
					&& $urandom_range(0, 3) == 0)
				idle_burst($urandom_range(1, 17));
			send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_angle());
		end

		@(negedge clk);
		start = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (STEPS + 16) @(posedge clk);

		$display("sent %0d items, checked %0d results, %0d of them clipped",
			items_sent, checked_count, clipped_count);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
